// ===== rtl/rlp_enc_pkg.sv =====
// Package for the RLP item encoder: action codes, RLP prefix constants
// and the payload types of the pipeline stages. No dependencies.
`default_nettype none

package rlp_enc_pkg;

    typedef enum logic [1:0] {
        ACT_INT   = 2'd0,
        ACT_STR   = 2'd1,
        ACT_EMPTY = 2'd2,
        ACT_LIST  = 2'd3
    } action_t;

    localparam logic [7:0] STR_BASE    = 8'h80;
    localparam logic [7:0] STR_LONG    = 8'hb7;
    localparam logic [7:0] LIST_BASE   = 8'hc0;
    localparam logic [7:0] LIST_LONG   = 8'hf7;
    localparam logic [7:0] SINGLE_MAX  = 8'h7f;
    localparam logic [5:0] SHORT_LIMIT = 6'd56;

    localparam int VALUE_W   = 64;
    localparam int MAX_BYTES = 8;
    // prefix + up to 8 length bytes + data byte
    localparam int RUN_MAX   = 10;
    localparam int CNT_W     = 4;

    // input as registered at the first stage
    typedef struct packed {
        action_t              action;
        logic [VALUE_W-1:0]   value;
        logic [7:0]           data_byte;
        logic                 first;
    } in_stage_t;

    // after byte-count search and value classification
    typedef struct packed {
        action_t              action;
        logic [VALUE_W-1:0]   value;
        logic [7:0]           data_byte;
        logic                 first;
        logic [CNT_W-1:0]     nbytes;
        logic                 is_zero;
        logic                 is_one;
        logic                 lt_short;
        logic                 lt_direct;
    } class_stage_t;

    // run layout decided, value left-aligned on its top nonzero byte
    typedef struct packed {
        logic                 has_prefix;
        logic [7:0]           prefix;
        logic                 use_be;
        logic [CNT_W-1:0]     nbytes;
        logic                 append;
        logic [7:0]           data_byte;
        logic [VALUE_W-1:0]   aligned;
    } plan_stage_t;

endpackage

`default_nettype wire

// ===== rtl/rlp_enc_if.sv =====
// Valid/ready channel interfaces of the RLP item encoder.
// Depends on rlp_enc_pkg for field widths.
`default_nettype none

interface rlp_enc_in_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        action;
    logic [rlp_enc_pkg::VALUE_W-1:0]   value;
    logic [7:0]                        data_byte;
    logic                              first;

    modport source (output valid, action, value, data_byte, first, input ready);
    modport sink   (input valid, action, value, data_byte, first, output ready);
endinterface

interface rlp_enc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, out_byte, last, input ready);
    modport sink   (input valid, out_byte, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/rlp_item_encoder.sv =====
// RLP item encoder top level: four-stage pipeline plus byte serializer.
// Depends on rlp_enc_pkg and the channel interfaces in rlp_enc_if.sv.
//
// Usage:
//   item   - one transfer per input item (action, value, data_byte, first).
//   result - one transfer per encoded byte; last marks the final byte of
//            the run caused by one item.
// Runs are 1 to 10 bytes. A string payload byte without header, a small
// integer, an empty string or a short list header is one byte.
// The first byte of an item reaches result through the input register and then
// the classify, align, assemble and serializer registers, in that order.
// Throughput: one output byte per cycle while result.ready is high. An item
// holds the serializer until its last byte goes, so single-byte items stream
// at one per cycle; longer runs push back on item.ready via the ready chain.
// Reset clears all stage valid bits; the payload registers are not reset.
// When result.ready is low the serializer holds its byte and each stage
// holds its item once the stage after it is full; nothing is dropped.
`default_nettype none

module rlp_item_encoder (
    input  wire logic          clk,
    input  wire logic          rst_n,
    rlp_enc_in_if.sink         item,
    rlp_enc_out_if.source      result
);

    localparam int VW = rlp_enc_pkg::VALUE_W;
    localparam int CW = rlp_enc_pkg::CNT_W;
    localparam int RM = rlp_enc_pkg::RUN_MAX;
    localparam int MB = rlp_enc_pkg::MAX_BYTES;

    // stage valid and ready chain
    logic v1_reg, v2_reg, v3_reg, v4_reg, ser_valid_reg;
    logic r1, r2, r3, r4, ser_ready;

    rlp_enc_pkg::in_stage_t    s1_reg;
    rlp_enc_pkg::class_stage_t s2_reg, s2_next;
    rlp_enc_pkg::plan_stage_t  s3_reg, s3_next;

    logic [7:0]    run_reg [RM];
    logic [7:0]    run_next [RM];
    logic [CW-1:0] cnt_reg, cnt_next;

    logic [7:0]    ser_reg [RM];
    logic [CW-1:0] left_reg;

    assign ser_ready  = !ser_valid_reg || (result.ready && left_reg == CW'(1));
    assign r4         = !v4_reg || ser_ready;
    assign r3         = !v3_reg || r4;
    assign r2         = !v2_reg || r3;
    assign r1         = !v1_reg || r2;
    assign item.ready = r1;

    assign result.valid    = ser_valid_reg;
    assign result.out_byte = ser_reg[0];
    assign result.last     = left_reg == CW'(1);

    // ---------------- stage 2: byte count and classification
    always_comb
    begin
        s2_next.action    = s1_reg.action;
        s2_next.value     = s1_reg.value;
        s2_next.data_byte = s1_reg.data_byte;
        s2_next.first     = s1_reg.first;
        s2_next.nbytes    = CW'(1);
        for (int b = 1; b < MB; b++)
        begin
            if (s1_reg.value[8*b +: 8] != 8'h00)
            begin
                s2_next.nbytes = CW'(b + 1);
            end
        end
        s2_next.is_zero   = s1_reg.value == '0;
        s2_next.is_one    = s1_reg.value == VW'(1);
        s2_next.lt_direct = s1_reg.value[VW-1:7] == '0;
        s2_next.lt_short  = (s1_reg.value[VW-1:6] == '0)
                            && (s1_reg.value[5:0] < rlp_enc_pkg::SHORT_LIMIT);
    end

    // ---------------- stage 3: run layout and alignment
    logic [2:0] align_sh;
    logic       str_hdr;

    always_comb
    begin
        align_sh = 3'(CW'(MB) - s2_reg.nbytes);
        str_hdr  = s2_reg.first
                   && !(s2_reg.is_one && s2_reg.data_byte <= rlp_enc_pkg::SINGLE_MAX);

        s3_next.has_prefix = 1'b1;
        s3_next.prefix     = rlp_enc_pkg::STR_BASE;
        s3_next.use_be     = 1'b0;
        s3_next.nbytes     = s2_reg.nbytes;
        s3_next.append     = 1'b0;
        s3_next.data_byte  = s2_reg.data_byte;
        s3_next.aligned    = s2_reg.value << {align_sh, 3'b000};

        unique case (s2_reg.action)
            rlp_enc_pkg::ACT_INT:
            begin
                if (s2_reg.is_zero)
                begin
                    s3_next.prefix = rlp_enc_pkg::STR_BASE;
                end
                else if (s2_reg.lt_direct)
                begin
                    s3_next.prefix = s2_reg.value[7:0];
                end
                else
                begin
                    s3_next.prefix = rlp_enc_pkg::STR_BASE + 8'(s2_reg.nbytes);
                    s3_next.use_be = 1'b1;
                end
            end
            rlp_enc_pkg::ACT_STR:
            begin
                s3_next.append = 1'b1;
                if (!str_hdr)
                begin
                    s3_next.has_prefix = 1'b0;
                end
                else if (s2_reg.lt_short)
                begin
                    s3_next.prefix = rlp_enc_pkg::STR_BASE + 8'(s2_reg.value[5:0]);
                end
                else
                begin
                    s3_next.prefix = rlp_enc_pkg::STR_LONG + 8'(s2_reg.nbytes);
                    s3_next.use_be = 1'b1;
                end
            end
            rlp_enc_pkg::ACT_EMPTY:
            begin
                s3_next.prefix = rlp_enc_pkg::STR_BASE;
            end
            rlp_enc_pkg::ACT_LIST:
            begin
                if (s2_reg.lt_short)
                begin
                    s3_next.prefix = rlp_enc_pkg::LIST_BASE + 8'(s2_reg.value[5:0]);
                end
                else
                begin
                    s3_next.prefix = rlp_enc_pkg::LIST_LONG + 8'(s2_reg.nbytes);
                    s3_next.use_be = 1'b1;
                end
            end
        endcase
    end

    // ---------------- stage 4: assemble the byte run
    logic [CW-1:0] be_n;
    logic [CW-1:0] data_idx;

    always_comb
    begin
        be_n     = s3_reg.use_be ? s3_reg.nbytes : '0;
        data_idx = CW'(s3_reg.has_prefix) + be_n;
        for (int i = 0; i < RM; i++)
        begin
            run_next[i] = 8'h00;
        end
        if (s3_reg.has_prefix)
        begin
            run_next[0] = s3_reg.prefix;
        end
        // big-endian bytes follow the prefix, MSB first
        for (int j = 0; j < MB; j++)
        begin
            if (CW'(j) < be_n)
            begin
                run_next[j + 1] = s3_reg.aligned[VW-1-8*j -: 8];
            end
        end
        if (s3_reg.append)
        begin
            run_next[data_idx] = s3_reg.data_byte;
        end
        cnt_next = data_idx + CW'(s3_reg.append);
    end

    // ---------------- control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            ser_valid_reg <= 1'b0;
        end
        else
        begin
            if (r1)        v1_reg        <= item.valid;
            if (r2)        v2_reg        <= v1_reg;
            if (r3)        v3_reg        <= v2_reg;
            if (r4)        v4_reg        <= v3_reg;
            if (ser_ready) ser_valid_reg <= v4_reg;
        end
    end

    // ---------------- payload registers
    always_ff @(posedge clk)
    begin
        if (r1 && item.valid)
        begin
            s1_reg.action    <= rlp_enc_pkg::action_t'(item.action);
            s1_reg.value     <= item.value;
            s1_reg.data_byte <= item.data_byte;
            s1_reg.first     <= item.first;
        end
        if (r2 && v1_reg)
        begin
            s2_reg <= s2_next;
        end
        if (r3 && v2_reg)
        begin
            s3_reg <= s3_next;
        end
        if (r4 && v3_reg)
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
        if (ser_ready)
        begin
            if (v4_reg)
            begin
                ser_reg  <= run_reg;
                left_reg <= cnt_reg;
            end
        end
        else if (result.ready)
        begin
            // byte transferred with more to follow: shift the run down
            for (int i = 0; i < RM - 1; i++)
            begin
                ser_reg[i] <= ser_reg[i + 1];
            end
            ser_reg[RM-1] <= 8'h00;
            left_reg      <= left_reg - CW'(1);
        end
    end

endmodule

`default_nettype wire
